### rtl/scanner_barcode_field_decoder_unit_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expands to one labeled concurrent assertion on the rising clock edge,
// disabled while reset is held low, or to nothing when ASSERT_OFF is defined.
`ifndef SCANNER_BARCODE_FIELD_DECODER_UNIT_MACROS_SVH
`define SCANNER_BARCODE_FIELD_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define SBFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define SBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define SBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/sbfd_pkg.sv
package sbfd_pkg;

    // Status codes carried by an end marker.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_NO_TERM  = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_SKIP = 1'b1;

    // Configuration write, one transfer per enabled cycle.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
    } t_cfg_wr;

    // Result group caused by one input character: up to three key-XORed bytes,
    // most significant first, then an optional end marker.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        has_end;
        t_status     status;
    } t_job;

    // Queue occupancy as seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/sbfd_front.sv
module sbfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbfd_pkg::t_cfg_wr  i_cfg,
    input  logic [7:0]         i_char_in,
    input  logic               i_line_end,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sbfd_pkg::t_q_status i_q_status,
    output logic               o_push,
    output sbfd_pkg::t_job     o_job
);
    import sbfd_pkg::*;

    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] XOR_KEY_RESET  = 8'd67;
    localparam logic [2:0] SEP_SKIP_RESET = 3'd3;

    // Returns {outside_alphabet, sextet}.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        case (c) inside
            [8'h61:8'h7A]: begin
                t = c - 8'h61;
                return {1'b0, t[5:0]};
            end
            [8'h41:8'h5A]: begin
                t = c - 8'h41 + 8'd26;
                return {1'b0, t[5:0]};
            end
            [8'h30:8'h39]: begin
                t = c - 8'h30 + 8'd52;
                return {1'b0, t[5:0]};
            end
            8'h2B:   return {1'b0, 6'd62};
            8'h2D:   return {1'b0, 6'd63};
            default: return {1'b1, 6'd0};
        endcase
    endfunction

    logic [7:0]  r_key;
    logic [2:0]  r_skip;
    logic [2:0]  r_dots,  n_dots;
    logic [17:0] r_buf,   n_buf;
    logic [1:0]  r_cnt,   n_cnt;
    logic        r_done,  n_done;
    logic        r_bad,   n_bad;

    logic        accept;
    logic        is_dot;
    logic [6:0]  sx;
    logic [23:0] fin_word;
    logic [1:0]  fin_nbytes;
    logic [23:0] key3;
    t_job        job;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_dot     = (i_char_in == CHAR_DOT);
    assign sx         = char_to_sextet(i_char_in);
    assign key3       = {r_key, r_key, r_key};

    always_comb begin
        case (r_cnt)
            2'd2: begin
                fin_word   = {r_buf[11:0], 12'd0};
                fin_nbytes = 2'd1;
            end
            2'd3: begin
                fin_word   = {r_buf, 6'd0};
                fin_nbytes = 2'd2;
            end
            default: begin
                fin_word   = 24'd0;
                fin_nbytes = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_dots = r_dots;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_done = r_done;
        n_bad  = r_bad;
        job    = '{word: fin_word ^ key3, nbytes: 2'd0, has_end: 1'b0, status: STATUS_OK};

        if (r_done) begin
            // drop everything until the line ends
        end else if (r_dots < r_skip) begin
            if (is_dot) begin
                n_dots = r_dots + 3'd1;
            end
            if (i_line_end) begin
                job.nbytes  = fin_nbytes;
                job.has_end = 1'b1;
                job.status  = STATUS_NO_TERM;
            end
        end else if (is_dot || i_line_end) begin
            job.nbytes  = fin_nbytes;
            job.has_end = 1'b1;
            job.status  = is_dot ? (r_bad ? STATUS_BAD_CHAR : STATUS_OK) : STATUS_NO_TERM;
            n_buf  = 18'd0;
            n_cnt  = 2'd0;
            n_done = 1'b1;
        end else begin
            if (sx[6]) begin
                n_bad = 1'b1;
            end
            if (r_cnt == 2'd3) begin
                job.word   = {r_buf, sx[5:0]} ^ key3;
                job.nbytes = 2'd3;
                n_buf      = 18'd0;
                n_cnt      = 2'd0;
            end else begin
                n_buf = {r_buf[11:0], sx[5:0]};
                n_cnt = r_cnt + 2'd1;
            end
        end

        if (i_line_end) begin
            n_dots = 3'd0;
            n_buf  = 18'd0;
            n_cnt  = 2'd0;
            n_done = 1'b0;
            n_bad  = 1'b0;
        end
    end

    assign o_push = accept && (job.has_end || (job.nbytes != 2'd0));
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= XOR_KEY_RESET;
            r_skip <= SEP_SKIP_RESET;
            r_dots <= 3'd0;
            r_buf  <= 18'd0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
            r_bad  <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_XOR_KEY:  r_key  <= i_cfg.data;
                    REG_SEP_SKIP: r_skip <= i_cfg.data[2:0];
                    default:      r_key  <= r_key;
                endcase
            end
            if (accept) begin
                r_dots <= n_dots;
                r_buf  <= n_buf;
                r_cnt  <= n_cnt;
                r_done <= n_done;
                r_bad  <= n_bad;
            end
        end
    end

endmodule

### rtl/sbfd_queue.sv
`include "scanner_barcode_field_decoder_unit_macros.svh"

module sbfd_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sbfd_pkg::t_job      i_job,
    input  logic                i_pop,
    output sbfd_pkg::t_job      o_head,
    output sbfd_pkg::t_q_status o_status
);
    import sbfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    t_job             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slots[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SBFD_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_status.full, "push into full queue")
    `SBFD_ASSERT_IMPL(a_q_count_range, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "queue count out of range")
    `SBFD_ASSERT_IMPL(a_q_empty_ptrs, i_clk, i_rst_n, o_status.empty, r_wr_ptr == r_rd_ptr, "empty queue with pointers apart")

endmodule

### rtl/sbfd_back.sv
`include "scanner_barcode_field_decoder_unit_macros.svh"

module sbfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbfd_pkg::t_job      i_head,
    input  sbfd_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic [7:0]          o_data_byte,
    output logic                o_byte_valid,
    output logic                o_code_end,
    output logic [1:0]          o_status,
    output logic                o_run_last,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import sbfd_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic [1:0] last_idx;
    logic       is_byte;
    logic       out_xfer;
    logic       free;

    assign last_idx = 2'(r_job.nbytes + {1'b0, r_job.has_end}) - 2'd1;
    assign is_byte  = (r_idx < r_job.nbytes);
    assign out_xfer = r_busy && i_out_ready;
    assign free     = !r_busy || (out_xfer && (r_idx == last_idx));
    assign o_pop    = free && !i_q_status.empty;

    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = r_job.word[23:16];
            2'd1:    o_data_byte = r_job.word[15:8];
            2'd2:    o_data_byte = r_job.word[7:0];
            default: o_data_byte = 8'd0;
        endcase
        if (!is_byte) begin
            o_data_byte = 8'd0;
        end
    end

    assign o_byte_valid = is_byte;
    assign o_code_end   = !is_byte;
    assign o_status     = is_byte ? STATUS_OK : r_job.status;
    assign o_run_last   = (r_idx == last_idx);
    assign o_out_valid  = r_busy;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (free) begin
            r_busy <= !i_q_status.empty;
            r_idx  <= 2'd0;
        end else if (out_xfer) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    `SBFD_ASSERT_NEXT(a_b_hold_idx, i_clk, i_rst_n, r_busy && !i_out_ready, $stable(r_idx) && r_busy, "result changed while stalled")
    `SBFD_ASSERT_IMPL(a_b_idx_range, i_clk, i_rst_n, r_busy, r_idx <= last_idx, "result index past group end")
    `SBFD_ASSERT_IMPL(a_b_end_last, i_clk, i_rst_n, r_busy && o_code_end, o_run_last, "end marker not last of group")

endmodule

### rtl/scanner_barcode_field_decoder_unit.sv
// Scanner barcode field decoder.
// Input channel (i_in_valid / o_in_ready): one line character per transfer, with
// i_line_end set on the final character of the line.
// Output channel (o_out_valid / i_out_ready): one result per transfer, either a
// decoded byte (o_byte_valid) or the field's end marker (o_code_end, o_status);
// o_run_last flags the last result caused by one input character.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 xor key, 1 separators to skip); write only while the block is idle.
// Throughput: one character per cycle while the job queue has room. A full group of
// four characters yields three bytes, drained one per cycle by the emitter while the
// receiver is ready, so on a steady stream the output side keeps up with one
// character per cycle. With the emitter idle, the first result of a character is
// valid once its transfer has written the queue and the queue head has then been
// loaded into the emitter register.
// Reset (synchronous, active low): line state and queue clear, key returns to 0x43
// and the separator count to 3; no clearing pass, the block is ready at once.
// A stalled receiver holds the current result; the front keeps accepting until the
// queue holds QUEUE_DEPTH result groups.
module scanner_barcode_field_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic [7:0]                     i_char_in,
    input  logic                           i_line_end,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output logic [7:0]                     o_data_byte,
    output logic                           o_byte_valid,
    output logic                           o_code_end,
    output logic [1:0]                     o_status,
    output logic                           o_run_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready
);
    import sbfd_pkg::*;

    t_cfg_wr   cfg;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Bundle the configuration write for the front.
    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    // Front: track separators and sextets, and pack sextets into result groups.
    sbfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_char_in  (i_char_in),
        .i_line_end (i_line_end),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Hold pending result groups so the front and the emitter stall on their own.
    sbfd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // Back: drain each group one result per transfer.
    sbfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_code_end   (o_code_end),
        .o_status     (o_status),
        .o_run_last   (o_run_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule
